// File: rtl/core/pid_pkg.sv
// shared types and constants of the discrete pid controller
// command and status structs between controller and datapath; no dependencies
`default_nettype none

package pid_pkg;

  // fixed point format
  localparam int ERR_W     = 16;
  localparam int FRAC_BITS = 8;
  localparam int ACC_W     = 48;
  localparam int TERM_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // divider: quotient bits retired per cycle
  localparam int DIV_STEP  = 4;
  localparam int DIV_ITERS = ACC_W / DIV_STEP;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_OUTER  = 2'd2,
    MODE_INNER  = 2'd3
  } pid_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN = 2'd0,
    CFG_TI   = 2'd1,
    CFG_TD   = 2'd2
  } pid_cfg_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_P,
    OP_D,
    OP_ACC_E,
    OP_ACC_Q,
    OP_I_DIV,
    OP_I_SUM,
    OP_I_ZERO,
    OP_SUM_DIV,
    OP_SUM_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_CLEAR,
    OP_SET_MODE,
    OP_OUT
  } pid_op_e;

  typedef struct packed {
    pid_op_e op;
    logic    use_err;
    logic    target_inner;
  } pid_cmd_t;

  typedef struct packed {
    logic ti_zero;
    logic inner_mode;
  } pid_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/pid_ctrl.sv
// sequencer of the discrete pid controller: request handshakes and datapath commands
// depends on pid_pkg
`default_nettype none

module pid_ctrl
  import pid_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           in_mode_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire pid_stat_t            stat_i,
  output pid_cmd_t                  cmd_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_P    = 4'd1;
  localparam logic [3:0] ST_D    = 4'd2;
  localparam logic [3:0] ST_ACC  = 4'd3;
  localparam logic [3:0] ST_IZ   = 4'd4;
  localparam logic [3:0] ST_DIVI = 4'd5;
  localparam logic [3:0] ST_DIVS = 4'd6;
  localparam logic [3:0] ST_IFIN = 4'd7;
  localparam logic [3:0] ST_ISUM = 4'd8;
  localparam logic [3:0] ST_MLO  = 4'd9;
  localparam logic [3:0] ST_MHI  = 4'd10;
  localparam logic [3:0] ST_MFIN = 4'd11;
  localparam logic [3:0] ST_MODE = 4'd12;
  localparam logic [3:0] ST_CLR  = 4'd13;
  localparam logic [3:0] ST_OUT  = 4'd14;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_ITERS - 1);

  logic [3:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  pid_mode_e            mode_q, mode_d;
  logic                 out_valid_q, out_valid_d;
  pid_mode_e            in_mode;
  logic                 want_inner;

  assign in_mode    = pid_mode_e'(in_mode_i);
  assign want_inner = (in_mode == MODE_INNER);

  always_comb begin
    state_d            = state_q;
    cnt_d              = cnt_q;
    mode_d             = mode_q;
    cmd_o.op           = OP_NONE;
    cmd_o.use_err      = (mode_q == MODE_SAMPLE) && stat_i.inner_mode;
    cmd_o.target_inner = (mode_q == MODE_INNER);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          mode_d   = in_mode;
          unique case (in_mode)
            MODE_SAMPLE: state_d = ST_P;
            MODE_CLEAR:  state_d = ST_CLR;
            MODE_OUTER, MODE_INNER: begin
              priority if (want_inner == stat_i.inner_mode) begin
                state_d = ST_OUT;
              end else if (stat_i.ti_zero) begin
                state_d = ST_MODE;
              end else if (want_inner) begin
                state_d = ST_DIVI;
              end else begin
                state_d = ST_MLO;
              end
            end
          endcase
        end
      end
      ST_P: begin
        cmd_o.op = OP_P;
        state_d  = ST_D;
      end
      ST_D: begin
        cmd_o.op = OP_D;
        priority if (stat_i.ti_zero) begin
          state_d = ST_IZ;
        end else if (stat_i.inner_mode) begin
          state_d = ST_DIVI;
        end else begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.op = OP_ACC_E;
        state_d  = ST_DIVI;
      end
      ST_IZ: begin
        cmd_o.op = OP_I_ZERO;
        state_d  = ST_OUT;
      end
      ST_DIVI: begin
        cmd_o.op = OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = ST_DIVS;
      end
      ST_DIVS: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = ST_IFIN;
        end
      end
      ST_IFIN: begin
        priority if (mode_q != MODE_SAMPLE) begin
          cmd_o.op = OP_SUM_DIV;
          state_d  = ST_MODE;
        end else if (stat_i.inner_mode) begin
          cmd_o.op = OP_ACC_Q;
          state_d  = ST_ISUM;
        end else begin
          cmd_o.op = OP_I_DIV;
          state_d  = ST_OUT;
        end
      end
      ST_ISUM: begin
        cmd_o.op = OP_I_SUM;
        state_d  = ST_OUT;
      end
      ST_MLO: begin
        cmd_o.op = OP_MUL_LO;
        state_d  = ST_MHI;
      end
      ST_MHI: begin
        cmd_o.op = OP_MUL_HI;
        state_d  = ST_MFIN;
      end
      ST_MFIN: begin
        cmd_o.op = OP_SUM_MUL;
        state_d  = ST_MODE;
      end
      ST_MODE: begin
        cmd_o.op = OP_SET_MODE;
        state_d  = ST_OUT;
      end
      ST_CLR: begin
        cmd_o.op = OP_CLEAR;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.op == OP_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      mode_q      <= MODE_SAMPLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // result register is only overwritten once its request is gone
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_OUT) |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while still pending");

  // an accepted request always starts work
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE))
    else $error("accepted request left the sequencer idle");

  // divider runs a fixed number of iterations
  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVI) |-> ##(DIV_ITERS + 1) (state_q == ST_IFIN))
    else $error("divider iteration count wrong");

  // a result appears only from the output state
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result valid raised outside the output state");

endmodule

`default_nettype wire

// File: rtl/core/pid_dpath.sv
// datapath of the discrete pid controller: registers, shared multiplier, radix-16 divider
// depends on pid_pkg; driven by commands from pid_ctrl
`default_nettype none

module pid_dpath
  import pid_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_W-1:0]         cfg_data_i,
  input  wire logic signed [ERR_W-1:0]  error_value_i,
  input  wire pid_cmd_t                 cmd_i,
  output pid_stat_t                     stat_o,
  output logic signed [TERM_W-1:0]      drive_o,
  output logic signed [TERM_W-1:0]      p_term_o,
  output logic signed [TERM_W-1:0]      i_term_o,
  output logic signed [TERM_W-1:0]      d_term_o
);

  localparam int HALF_W     = ACC_W / 2;
  localparam int MUL_A_W    = HALF_W + 1;
  localparam int MUL_B_W    = CFG_W + 1;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int PART_W     = HALF_W + CFG_W;
  localparam int PROD_W     = ACC_W + CFG_W;
  localparam int DIVIDEND_W = ACC_W + FRAC_BITS;

  localparam logic signed [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [TERM_W-1:0] TERM_MAX = {1'b0, {(TERM_W-1){1'b1}}};
  localparam logic signed [TERM_W-1:0] TERM_MIN = {1'b1, {(TERM_W-1){1'b0}}};
  localparam logic [CFG_W-1:0]         GAIN_RST = CFG_W'(1 << FRAC_BITS);

  // trunc(x / 2^FRAC_BITS) toward zero
  function automatic logic signed [TERM_W-1:0] rescale(input logic signed [MUL_P_W-1:0] x);
    logic signed [MUL_P_W-1:0] t;
    t = x + (x[MUL_P_W-1] ? {{(MUL_P_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}} : '0);
    return t[FRAC_BITS +: TERM_W];
  endfunction

  // sign and magnitude to accumulator range, saturating
  function automatic logic signed [ACC_W-1:0] mag_to_acc(input logic neg,
                                                      input logic [DIVIDEND_W-1:0] m);
    logic [ACC_W-1:0] t;
    t = ~m[ACC_W-1:0] + ACC_W'(1);
    if (!neg) begin
      return (|m[DIVIDEND_W-1:ACC_W-1]) ? ACC_MAX : m[ACC_W-1:0];
    end else if ((|m[DIVIDEND_W-1:ACC_W]) || (m[ACC_W-1] && (|m[ACC_W-2:0]))) begin
      return ACC_MIN;
    end else begin
      return t;
    end
  endfunction

  // sign and magnitude to term range, saturating
  function automatic logic signed [TERM_W-1:0] mag_to_term(input logic neg,
                                                        input logic [DIVIDEND_W-1:0] m);
    logic [TERM_W-1:0] t;
    t = ~m[TERM_W-1:0] + TERM_W'(1);
    if (!neg) begin
      return (|m[DIVIDEND_W-1:TERM_W-1]) ? TERM_MAX : m[TERM_W-1:0];
    end else if ((|m[DIVIDEND_W-1:TERM_W]) || (m[TERM_W-1] && (|m[TERM_W-2:0]))) begin
      return TERM_MIN;
    end else begin
      return t;
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] acc_add(input logic signed [ACC_W-1:0] a,
                                                   input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [TERM_W-1:0] acc_to_term(input logic signed [ACC_W-1:0] x);
    if ((&x[ACC_W-1:TERM_W-1]) || !(|x[ACC_W-1:TERM_W-1])) begin
      return x[TERM_W-1:0];
    end
    return x[ACC_W-1] ? TERM_MIN : TERM_MAX;
  endfunction

  // configuration and controller state
  logic [CFG_W-1:0]         gain_q, ti_q, td_q;
  logic signed [ACC_W-1:0]  sum_q;
  logic signed [ERR_W-1:0]  prev_q;
  logic                     inner_q;
  logic signed [TERM_W-1:0] last_p_q, last_i_q, last_d_q;

  // working registers
  logic signed [ERR_W-1:0]  err_q;
  logic [ACC_W-1:0]         div_q;
  logic [CFG_W-1:0]         rem_q;
  logic                     neg_q, ovf_q;
  logic [PART_W-1:0]        mul_lo_q, mul_hi_q;
  logic signed [TERM_W-1:0] drive_q, p_out_q, i_out_q, d_out_q;

  logic [ACC_W-1:0]          sum_u, sum_mag;
  logic [ERR_W-1:0]          err_u, err_mag;
  logic signed [ERR_W:0]     diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic [ACC_W-1:0]          div_a;
  logic [FRAC_BITS-1:0]      div_head;
  logic [ACC_W-1:0]          div_q_nx;
  logic [CFG_W-1:0]          rem_nx;
  logic [DIVIDEND_W-1:0]     div_m;
  logic [PROD_W-1:0]         mul_total;
  logic [DIVIDEND_W-1:0]     mul_m;
  logic signed [ACC_W-1:0]   div_acc;
  logic signed [TERM_W+1:0]  drive_sum;
  logic signed [TERM_W-1:0]  drive_sat;

  assign sum_u   = sum_q;
  assign sum_mag = sum_q[ACC_W-1] ? (~sum_u + ACC_W'(1)) : sum_u;
  assign err_u   = err_q;
  assign err_mag = err_q[ERR_W-1] ? (~err_u + ERR_W'(1)) : err_u;
  assign diff    = {err_q[ERR_W-1], err_q} - {prev_q[ERR_W-1], prev_q};

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_P: begin
        mul_a = {{(MUL_A_W-ERR_W){err_q[ERR_W-1]}}, err_q};
        mul_b = {1'b0, gain_q};
      end
      OP_D: begin
        mul_a = {{(MUL_A_W-ERR_W-1){diff[ERR_W]}}, diff};
        mul_b = {1'b0, td_q};
      end
      OP_MUL_LO: begin
        mul_a = {1'b0, sum_mag[HALF_W-1:0]};
        mul_b = {1'b0, ti_q};
      end
      OP_MUL_HI: begin
        mul_a = {1'b0, sum_mag[ACC_W-1:HALF_W]};
        mul_b = {1'b0, ti_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // divider setup and one radix step
  assign div_a    = cmd_i.use_err ? {{(ACC_W-ERR_W){1'b0}}, err_mag} : sum_mag;
  assign div_head = div_a[ACC_W-1 -: FRAC_BITS];

  always_comb begin
    logic [CFG_W:0] trial;
    div_q_nx = div_q;
    rem_nx   = rem_q;
    trial    = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial    = {rem_nx, div_q_nx[ACC_W-1]};
      div_q_nx = {div_q_nx[ACC_W-2:0], 1'b0};
      if (trial >= {1'b0, ti_q}) begin
        rem_nx      = CFG_W'(trial - {1'b0, ti_q});
        div_q_nx[0] = 1'b1;
      end else begin
        rem_nx = trial[CFG_W-1:0];
      end
    end
  end

  assign div_m     = ovf_q ? {DIVIDEND_W{1'b1}} : {{FRAC_BITS{1'b0}}, div_q};
  assign div_acc   = mag_to_acc(neg_q, div_m);
  assign mul_total = {mul_hi_q, {HALF_W{1'b0}}} + {{(PROD_W-PART_W){1'b0}}, mul_lo_q};
  assign mul_m     = mul_total[PROD_W-1:FRAC_BITS];

  assign drive_sum = {{2{last_p_q[TERM_W-1]}}, last_p_q}
                   + {{2{last_i_q[TERM_W-1]}}, last_i_q}
                   + {{2{last_d_q[TERM_W-1]}}, last_d_q};
  assign drive_sat = ((&drive_sum[TERM_W+1:TERM_W-1]) || !(|drive_sum[TERM_W+1:TERM_W-1]))
                   ? drive_sum[TERM_W-1:0]
                   : (drive_sum[TERM_W+1] ? TERM_MIN : TERM_MAX);

  // controller state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_RST;
      ti_q     <= '0;
      td_q     <= '0;
      sum_q    <= '0;
      prev_q   <= '0;
      inner_q  <= 1'b0;
      last_p_q <= '0;
      last_i_q <= '0;
      last_d_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (pid_cfg_e'(cfg_index_i))
          CFG_GAIN: gain_q <= cfg_data_i;
          CFG_TI:   ti_q   <= cfg_data_i;
          CFG_TD:   td_q   <= cfg_data_i;
          default:  ;
        endcase
      end
      unique case (cmd_i.op)
        OP_P:       last_p_q <= rescale(prod);
        OP_D: begin
          last_d_q <= rescale(prod);
          prev_q   <= err_q;
        end
        OP_ACC_E:   sum_q    <= acc_add(sum_q, {{(ACC_W-ERR_W){err_q[ERR_W-1]}}, err_q});
        OP_ACC_Q:   sum_q    <= acc_add(sum_q, div_acc);
        OP_I_DIV:   last_i_q <= mag_to_term(neg_q, div_m);
        OP_I_SUM:   last_i_q <= acc_to_term(sum_q);
        OP_I_ZERO:  last_i_q <= '0;
        OP_SUM_DIV: sum_q    <= div_acc;
        OP_SUM_MUL: sum_q    <= mag_to_acc(sum_q[ACC_W-1], mul_m);
        OP_CLEAR: begin
          sum_q    <= '0;
          prev_q   <= '0;
          last_i_q <= '0;
        end
        OP_SET_MODE: inner_q <= cmd_i.target_inner;
        default: ;
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: err_q <= error_value_i;
      OP_DIV_INIT: begin
        div_q <= {div_a[ACC_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        rem_q <= {{(CFG_W-FRAC_BITS){1'b0}}, div_head};
        ovf_q <= ({{(CFG_W-FRAC_BITS){1'b0}}, div_head} >= ti_q);
        neg_q <= cmd_i.use_err ? err_q[ERR_W-1] : sum_q[ACC_W-1];
      end
      OP_DIV_STEP: begin
        div_q <= div_q_nx;
        rem_q <= rem_nx;
      end
      OP_MUL_LO: mul_lo_q <= prod[PART_W-1:0];
      OP_MUL_HI: mul_hi_q <= prod[PART_W-1:0];
      OP_OUT: begin
        drive_q <= drive_sat;
        p_out_q <= last_p_q;
        i_out_q <= last_i_q;
        d_out_q <= last_d_q;
      end
      default: ;
    endcase
  end

  assign stat_o.ti_zero    = (ti_q == '0);
  assign stat_o.inner_mode = inner_q;

  assign drive_o  = drive_q;
  assign p_term_o = p_out_q;
  assign i_term_o = i_out_q;
  assign d_term_o = d_out_q;

endmodule

`default_nettype wire

// File: rtl/core/discrete_pid_controller.sv
// top level of the discrete pid controller: sequencer plus datapath
// depends on pid_pkg, pid_ctrl and pid_dpath
// work per request: a sample forms the p and d terms and the integral, the integral through the
//   divider unless ti is zero; clear zeroes the integral and previous error; a mode switch divides
//   (to inner) or multiplies (to outer) the integral by ti, unless the mode is unchanged or ti is zero
// one request in flight; next request accepted the cycle after its result is registered;
//   the radix-16 divider is the longest step of a full sample
// reset: asynchronous active low; gain 1.0, ti and td zero, integral, previous error, outer mode
//   and last terms cleared; no result pending
`default_nettype none

module discrete_pid_controller
  import pid_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write port
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_W-1:0]         cfg_data_i,
  // request channel
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [1:0]               mode_i,
  input  wire logic signed [ERR_W-1:0]  error_value_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [TERM_W-1:0]      drive_o,
  output logic signed [TERM_W-1:0]      p_term_o,
  output logic signed [TERM_W-1:0]      i_term_o,
  output logic signed [TERM_W-1:0]      d_term_o
);

  // command and status between sequencer and datapath
  pid_cmd_t  cmd;
  pid_stat_t stat;

  // sequencer: walks each request through the multiply, accumulate, divide or clear steps its mode needs
  pid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_mode_i   (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: config, integral state, shared multiplier, divider, result register
  pid_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .error_value_i (error_value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .drive_o       (drive_o),
    .p_term_o      (p_term_o),
    .i_term_o      (i_term_o),
    .d_term_o      (d_term_o)
  );

endmodule

`default_nettype wire

// File: test/tb_top.sv
// testbench of the discrete pid controller: directed table, then random phases
// expected terms come from a fixed point pid predictor kept inside this file or from typed table rows; needs pid_pkg
`timescale 1ns / 1ps

module tb_top;
  import pid_pkg::*;

  // run length and limits
  localparam int ITEMS_TOTAL = 1300;
  localparam int CALM_ITEMS  = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 400000;

  localparam longint ACC_MAX  = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint TERM_MAX = (longint'(1) <<< (TERM_W - 1)) - 1;

  typedef struct packed {
    logic signed [TERM_W-1:0] drive;
    logic signed [TERM_W-1:0] p_term;
    logic signed [TERM_W-1:0] i_term;
    logic signed [TERM_W-1:0] d_term;
  } pid_terms_t;

  // one row of the directed table: a register write or a request
  typedef struct packed {
    logic                    is_reg;
    pid_cfg_e                reg_sel;
    logic [CFG_W-1:0]        reg_val;
    pid_mode_e               mode;
    logic signed [ERR_W-1:0] err;
    logic                    typed;
    pid_terms_t              want;
  } plan_row_t;

  localparam pid_terms_t ZERO_TERMS = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
  localparam pid_terms_t POS_FULL   = '{32'sd32767, 32'sd32767, 32'sd0, 32'sd0};
  localparam pid_terms_t NEG_FULL   = '{-32'sd32768, -32'sd32768, 32'sd0, 32'sd0};

  localparam int PLAN_LEN = 34;
  localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
    // reset settings: gain 1.0, no integral, no derivative
    '{1'b0, CFG_GAIN, 16'd0,     MODE_CLEAR,  16'sd0,      1'b1, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_SAMPLE, 16'sd0,      1'b1, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_SAMPLE, 16'sd32767,  1'b1, POS_FULL},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_SAMPLE, -16'sd32768, 1'b1, NEG_FULL},
    // mode switches with ti zero only flip the mode bit
    '{1'b0, CFG_GAIN, 16'd0,     MODE_INNER,  16'sd0,      1'b1, NEG_FULL},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_OUTER,  16'sd0,      1'b1, NEG_FULL},
    // full gains, ti 1.0
    '{1'b1, CFG_GAIN, 16'hFFFF,  MODE_SAMPLE, 16'sd0,      1'b0, ZERO_TERMS},
    '{1'b1, CFG_TI,   16'd256,   MODE_SAMPLE, 16'sd0,      1'b0, ZERO_TERMS},
    '{1'b1, CFG_TD,   16'hFFFF,  MODE_SAMPLE, 16'sd0,      1'b0, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_SAMPLE, 16'sd32767,  1'b0, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_SAMPLE, -16'sd32768, 1'b0, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_INNER,  16'sd0,      1'b0, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_SAMPLE, 16'sd12345,  1'b0, ZERO_TERMS},
    // switch to the mode already set, then back to outer
    '{1'b0, CFG_GAIN, 16'd0,     MODE_INNER,  16'sd0,      1'b0, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_OUTER,  16'sd0,      1'b0, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_CLEAR,  16'sd77,     1'b0, ZERO_TERMS},
    // tiny ti: rescales push the accumulator into saturation
    '{1'b1, CFG_GAIN, 16'd0,     MODE_SAMPLE, 16'sd0,      1'b0, ZERO_TERMS},
    '{1'b1, CFG_TI,   16'd1,     MODE_SAMPLE, 16'sd0,      1'b0, ZERO_TERMS},
    '{1'b1, CFG_TD,   16'd1,     MODE_SAMPLE, 16'sd0,      1'b0, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_SAMPLE, 16'sd32767,  1'b0, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_INNER,  16'sd0,      1'b0, ZERO_TERMS},
    '{1'b1, CFG_TI,   16'hFFFF,  MODE_SAMPLE, 16'sd0,      1'b0, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_OUTER,  16'sd0,      1'b0, ZERO_TERMS},
    '{1'b1, CFG_TI,   16'd1,     MODE_SAMPLE, 16'sd0,      1'b0, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_SAMPLE, -16'sd1,     1'b0, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_INNER,  16'sd0,      1'b0, ZERO_TERMS},
    '{1'b1, CFG_TI,   16'hFFFF,  MODE_SAMPLE, 16'sd0,      1'b0, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_OUTER,  16'sd0,      1'b0, ZERO_TERMS},
    '{1'b1, CFG_TI,   16'd1,     MODE_SAMPLE, 16'sd0,      1'b0, ZERO_TERMS},
    '{1'b1, CFG_GAIN, 16'hFFFF,  MODE_SAMPLE, 16'sd0,      1'b0, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_INNER,  16'sd0,      1'b0, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_SAMPLE, -16'sd32768, 1'b0, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_SAMPLE, 16'sd32767,  1'b0, ZERO_TERMS},
    '{1'b0, CFG_GAIN, 16'd0,     MODE_CLEAR,  16'sd0,      1'b0, ZERO_TERMS}
  };

  // dut ports
  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_W-1:0]        cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [1:0]              mode_i;
  logic signed [ERR_W-1:0] error_value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [TERM_W-1:0] drive_o;
  logic signed [TERM_W-1:0] p_term_o;
  logic signed [TERM_W-1:0] i_term_o;
  logic signed [TERM_W-1:0] d_term_o;

  discrete_pid_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .error_value_i (error_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .drive_o       (drive_o),
    .p_term_o      (p_term_o),
    .i_term_o      (i_term_o),
    .d_term_o      (d_term_o)
  );

  // predictor copy of registers and controller state
  logic [CFG_W-1:0] gain_reg;
  logic [CFG_W-1:0] ti_reg;
  logic [CFG_W-1:0] td_reg;
  longint           integ_sum;
  longint           prev_err;
  bit               inner_mode_q;
  longint           p_last;
  longint           i_last;
  longint           d_last;

  pid_terms_t expected_terms[$];

  int  errors;
  int  reported;
  int  cycle_count;
  int  items_done;
  bit  calm;
  bit  long_hold_req;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // fixed point helpers of the predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp_term(longint x);
    if (x > TERM_MAX) return TERM_MAX;
    if (x < -TERM_MAX - 1) return -TERM_MAX - 1;
    return x;
  endfunction

  // product rescale, truncating toward zero
  function automatic longint drop_frac(longint x);
    if (x < 0) return -((-x) >>> FRAC_BITS);
    return x >>> FRAC_BITS;
  endfunction

  function automatic longint unsigned magnitude_of(longint x);
    if (x < 0) return longint'(-x);
    return x;
  endfunction

  // rebuild a signed value from sign and magnitude, saturated to [-lim-1, lim]
  function automatic longint signed_of(bit neg, longint unsigned m, longint unsigned lim);
    if (!neg) return (m > lim) ? longint'(lim) : longint'(m);
    if (m > lim) m = lim + 1;
    return -longint'(m);
  endfunction

  // trunc(x * 2^FRAC_BITS / t)
  function automatic longint scaled_quotient(longint x, longint unsigned t,
                                             longint unsigned lim);
    longint unsigned a;
    longint unsigned q;
    longint unsigned r;
    a = magnitude_of(x);
    q = a / t;
    r = a % t;
    if (q > ((lim + 1) >> FRAC_BITS)) return signed_of(x < 0, lim + 1, lim);
    return signed_of(x < 0, (q << FRAC_BITS) + ((r << FRAC_BITS) / t), lim);
  endfunction

  // trunc(x * t / 2^FRAC_BITS)
  function automatic longint scaled_product(longint x, longint unsigned t,
                                            longint unsigned lim);
    longint unsigned a;
    longint unsigned hi;
    longint unsigned lo;
    a = magnitude_of(x);
    if ((a >> FRAC_BITS) > lim / t) return signed_of(x < 0, lim + 1, lim);
    hi = (a >> FRAC_BITS) * t;
    lo = ((a & ((longint'(1) << FRAC_BITS) - 1)) * t) >> FRAC_BITS;
    if (hi > lim + 1 - lo) return signed_of(x < 0, lim + 1, lim);
    return signed_of(x < 0, hi + lo, lim);
  endfunction

  function automatic longint acc_sat_add(longint a, longint b);
    if (b > 0 && a > ACC_MAX - b) return ACC_MAX;
    if (b < 0 && a < -ACC_MAX - 1 - b) return -ACC_MAX - 1;
    return a + b;
  endfunction

  // advance the predicted controller by one request and return its result
  function automatic pid_terms_t pid_predict(pid_mode_e mode, logic signed [ERR_W-1:0] err);
    longint     e;
    longint     total;
    bit         want_inner;
    pid_terms_t res;
    e = longint'(err);
    case (mode)
      MODE_SAMPLE: begin
        p_last = clamp_term(drop_frac(longint'(gain_reg) * e));
        i_last = 0;
        if (ti_reg != 0) begin
          if (!inner_mode_q) begin
            integ_sum = acc_sat_add(integ_sum, e);
            i_last = scaled_quotient(integ_sum, ti_reg, TERM_MAX);
          end else begin
            integ_sum = acc_sat_add(integ_sum, scaled_quotient(e, ti_reg, ACC_MAX));
            i_last = clamp_term(integ_sum);
          end
        end
        d_last = 0;
        if (td_reg != 0) d_last = clamp_term(drop_frac(longint'(td_reg) * (e - prev_err)));
        prev_err = e;
      end
      MODE_CLEAR: begin
        integ_sum = 0;
        prev_err = 0;
        i_last = 0;
      end
      default: begin
        // a switch rescales the accumulator unless ti is zero or the mode is unchanged
        want_inner = (mode == MODE_INNER);
        if (want_inner != inner_mode_q) begin
          if (ti_reg != 0) begin
            if (want_inner) integ_sum = scaled_quotient(integ_sum, ti_reg, ACC_MAX);
            else integ_sum = scaled_product(integ_sum, ti_reg, ACC_MAX);
          end
          inner_mode_q = want_inner;
        end
      end
    endcase
    total = clamp_term(p_last + i_last + d_last);
    res.drive  = total[TERM_W-1:0];
    res.p_term = p_last[TERM_W-1:0];
    res.i_term = i_last[TERM_W-1:0];
    res.d_term = d_last[TERM_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driving tasks
  // ---------------------------------------------------------------------------

  // register write with the request channel idle
  task automatic write_reg(pid_cfg_e sel, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (sel)
      CFG_GAIN: gain_reg = val;
      CFG_TI:   ti_reg = val;
      CFG_TD:   td_reg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // drop valid and wait until every expected result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_terms.size() != 0) @(posedge clk_i);
  endtask

  // offer one request after an optional gap, then record its expected result
  task automatic send_request(pid_mode_e mode, logic signed [ERR_W-1:0] err, bit typed,
                              pid_terms_t typed_terms, int gap);
    pid_terms_t predicted;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    error_value_i <= err;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = pid_predict(mode, err);
    // rows with a typed result are checked against that value
    expected_terms.push_back(typed ? typed_terms : predicted);
    items_done++;
  endtask

  // setting values lean toward the extremes
  function automatic logic [CFG_W-1:0] pick_setting();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 16'd1;
      3:       return 16'd256;
      default: return CFG_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result side: ready pattern and checking
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned span;
    out_ready_i = 1'b0;
    @(negedge clk_i);
    forever begin
      if (long_hold_req) begin
        // long hold-off so that the block fills and stalls its request side
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        span = $urandom_range(1, 11);
        repeat (span) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        span = $urandom_range(1, 40);
        repeat (span) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    pid_terms_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_terms.size() == 0) begin
        errors++;
        if (reported < 10)
          $display("unexpected result at cycle %0d: drive %0d p %0d i %0d d %0d",
                   cycle_count, drive_o, p_term_o, i_term_o, d_term_o);
        reported++;
      end else begin
        want = expected_terms.pop_front();
        if (drive_o !== want.drive || p_term_o !== want.p_term ||
            i_term_o !== want.i_term || d_term_o !== want.d_term) begin
          errors++;
          if (reported < 10)
            $display({"mismatch at cycle %0d (expected/actual): drive %0d/%0d ",
                      "p %0d/%0d i %0d/%0d d %0d/%0d"}, cycle_count,
                     want.drive, drive_o, want.p_term, p_term_o,
                     want.i_term, i_term_o, want.d_term, d_term_o);
          reported++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int                      phase;
    int                      len;
    int                      burst_odds;
    int                      gap;
    int unsigned             pick;
    pid_mode_e               mode;
    logic signed [ERR_W-1:0] err;

    errors        = 0;
    reported      = 0;
    cycle_count   = 0;
    items_done    = 0;
    calm          = 1'b0;
    long_hold_req = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    mode_i        = '0;
    error_value_i = '0;

    // predictor reset state
    gain_reg     = 16'd256;
    ti_reg       = '0;
    td_reg       = '0;
    integ_sum    = 0;
    prev_err     = 0;
    inner_mode_q = 1'b0;
    p_last       = 0;
    i_last       = 0;
    d_last       = 0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int k = 0; k < PLAN_LEN; k++) begin
      if (PLAN[k].is_reg) begin
        wait_drained();
        write_reg(PLAN[k].reg_sel, PLAN[k].reg_val);
      end else begin
        send_request(PLAN[k].mode, PLAN[k].err, PLAN[k].typed, PLAN[k].want, 0);
      end
    end

    // random phases, each with fresh register settings
    phase = 0;
    while (items_done < ITEMS_TOTAL) begin
      wait_drained();
      calm = (items_done >= ITEMS_TOTAL - CALM_ITEMS);
      write_reg(CFG_GAIN, pick_setting());
      write_reg(CFG_TI, pick_setting());
      write_reg(CFG_TD, pick_setting());
      burst_odds = calm ? 0 : $urandom_range(0, 4);
      if (phase == 2) long_hold_req = 1'b1;
      len = $urandom_range(40, 120);
      for (int n = 0; n < len && items_done < ITEMS_TOTAL; n++) begin
        // sender pause in the middle of one phase
        if (phase == 4 && n == len / 2) wait_drained();
        pick = $urandom_range(0, 19);
        if (pick == 0) mode = MODE_CLEAR;
        else if (pick <= 2) mode = MODE_OUTER;
        else if (pick <= 4) mode = MODE_INNER;
        else mode = MODE_SAMPLE;
        case ($urandom_range(0, 7))
          0:       err = 16'sd32767;
          1:       err = -16'sd32768;
          2:       err = ERR_W'(int'($urandom_range(0, 511)) - 256);
          default: err = ERR_W'($urandom);
        endcase
        gap = 0;
        if (burst_odds != 0 && $urandom_range(1, 8) <= burst_odds) gap = $urandom_range(1, 11);
        send_request(mode, err, 1'b0, ZERO_TERMS, gap);
      end
      phase++;
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
